[rtl/fpa_pkg.sv]
package fpa_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 8;

  typedef enum logic [3:0] {
    MODE_ADD  = 4'd0,
    MODE_SUB  = 4'd1,
    MODE_MUL  = 4'd2,
    MODE_DIV  = 4'd3,
    MODE_GT   = 4'd4,
    MODE_LT   = 4'd5,
    MODE_GE   = 4'd6,
    MODE_LE   = 4'd7,
    MODE_EQ   = 4'd8,
    MODE_NE   = 4'd9,
    MODE_INC  = 4'd10,
    MODE_DEC  = 4'd11,
    MODE_MAX  = 4'd12,
    MODE_MIN  = 4'd13,
    MODE_ITOF = 4'd14,
    MODE_FTOI = 4'd15
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_SAT      = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    mode_t                         mode;
    logic signed [DATA_WIDTH-1:0]  operand_a;
    logic signed [DATA_WIDTH-1:0]  operand_b;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  result;
    logic                          compare_true;
    status_t                       status;
  } out_item_t;

  // Bit positions of the side information that rides along the divider.
  localparam int TAG_BZ  = 0;
  localparam int TAG_NEG = 1;
  localparam int TAG_DIV = 2;
  localparam int TAG_W   = 3;

endpackage

[rtl/fpa_div_pipe.sv]
// Unsigned restoring divider, one quotient bit per pipeline stage.
// The numerator is the dividend shifted left by FB bits.
module fpa_div_pipe #(
  parameter int DW = fpa_pkg::DATA_WIDTH,
  parameter int FB = fpa_pkg::FRAC_BITS,
  parameter int TW = fpa_pkg::TAG_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [DW-1:0]    in_num,
  input  logic [DW-1:0]    in_den,
  input  logic [TW-1:0]    in_tag,
  output logic             out_valid,
  output logic [DW+FB-1:0] out_quo,
  output logic [DW-1:0]    out_rem,
  output logic [DW-1:0]    out_den,
  output logic [TW-1:0]    out_tag
);

  localparam int NW = DW + FB;

  logic          v_r   [NW];
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] acc_r [NW];
  logic [DW-1:0] den_r [NW];
  logic [TW-1:0] tag_r [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic          v_in;
    logic [DW-1:0] rem_in;
    logic [NW-1:0] acc_in;
    logic [DW-1:0] den_in;
    logic [TW-1:0] tag_in;
    logic [DW:0]   trial;
    logic          ge;

    if (g == 0) begin : g_head
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign acc_in = {in_num, {FB{1'b0}}};
      assign den_in = in_den;
      assign tag_in = in_tag;
    end else begin : g_body
      assign v_in   = v_r[g-1];
      assign rem_in = rem_r[g-1];
      assign acc_in = acc_r[g-1];
      assign den_in = den_r[g-1];
      assign tag_in = tag_r[g-1];
    end

    // Bring down the next numerator bit and try to subtract the divisor.
    assign trial = {rem_in, acc_in[NW-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[g] <= 1'b0;
      end else begin
        v_r[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[g] <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
      acc_r[g] <= {acc_in[NW-2:0], ge};
      den_r[g] <= den_in;
      tag_r[g] <= tag_in;
    end
  end

  assign out_valid = v_r[NW-1];
  assign out_quo   = acc_r[NW-1];
  assign out_rem   = rem_r[NW-1];
  assign out_den   = den_r[NW-1];
  assign out_tag   = tag_r[NW-1];

endmodule

[rtl/fixed_point_alu.sv]
// Signed fixed-point ALU, 32-bit raw values with FRAC_BITS fraction bits.
// One item is taken at every clock edge where start is high; busy is always
// low, because the pipeline never stalls. Each item produces exactly one
// result, shown on out_item for a single cycle with out_valid high, in the
// same order the items came in. The receiver cannot hold results off, so it
// must take every result in the cycle it is shown. Every operation has the
// same latency. The divider sets it: it resolves one quotient bit per
// pipeline stage across the 40-bit shifted numerator, and is followed by a
// rounding stage, a sign and select stage and the output saturation stage.
// All other operations run through a shorter path and wait in a delay line
// so results leave in order. Multiply and divide round to nearest, ties away
// from zero; results that overflow saturate with status 1, and division by
// zero returns zero with status 2.
module fixed_point_alu #(
  parameter int FRAC_BITS = fpa_pkg::FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  fpa_pkg::in_item_t  in_item,
  output logic               out_valid,
  output fpa_pkg::out_item_t out_item
);

  localparam int DW = fpa_pkg::DATA_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int NW = DW + FB;      // divider numerator and quotient width
  localparam int VW = DW + FB + 1;  // signed width of unclamped results
  localparam int PW = 2 * DW;       // product width
  localparam int HW = DW / 2;       // split point of the multiplier
  localparam int MW = PW - FB;      // width of the scaled product magnitude
  localparam int DL = NW - 1;       // delay line depth for the short path
  localparam int TW = fpa_pkg::TAG_W;

  localparam logic [PW-1:0]        HALF   = PW'(1) << (FB - 1);
  localparam logic [MW-1:0]        LIM_M  = MW'(1) << (DW - 1);
  localparam logic [NW:0]          LIM_Q  = (NW + 1)'(1) << (DW - 1);
  localparam logic signed [VW-1:0] CLIP   = (VW'(1) << (DW - 1)) + VW'(1);
  localparam logic signed [VW-1:0] SAT_MAX = {{(FB + 2){1'b0}}, {(DW - 1){1'b1}}};
  localparam logic signed [VW-1:0] SAT_MIN = {{(FB + 2){1'b1}}, {(DW - 1){1'b0}}};

  // The pipeline never stalls, so an item is taken whenever start is high.
  assign busy = 1'b0;

  // ---------------------------------------------------------------------
  // Stage 1: register the item and form operand magnitudes and signs.
  // ---------------------------------------------------------------------
  logic [DW-1:0]           a_u, b_u;
  logic                    v1_r;
  fpa_pkg::mode_t          mode1_r;
  logic signed [DW-1:0]    a1_r, b1_r;
  logic [DW-1:0]           ma1_r, mb1_r;
  logic                    neg1_r, bz1_r;

  assign a_u = in_item.operand_a;
  assign b_u = in_item.operand_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    mode1_r <= in_item.mode;
    a1_r    <= in_item.operand_a;
    b1_r    <= in_item.operand_b;
    ma1_r   <= a_u[DW-1] ? (~a_u + DW'(1)) : a_u;
    mb1_r   <= b_u[DW-1] ? (~b_u + DW'(1)) : b_u;
    neg1_r  <= a_u[DW-1] ^ b_u[DW-1];
    bz1_r   <= (b_u == '0);
  end

  // ---------------------------------------------------------------------
  // Divider: the long path. Its valid chain is the pipeline's valid chain.
  // ---------------------------------------------------------------------
  logic [TW-1:0] tag1;
  logic          dv_valid;
  logic [NW-1:0] dv_quo;
  logic [DW-1:0] dv_rem, dv_den;
  logic [TW-1:0] dv_tag;

  always_comb begin
    tag1          = '0;
    tag1[fpa_pkg::TAG_BZ]  = bz1_r;
    tag1[fpa_pkg::TAG_NEG] = neg1_r;
    tag1[fpa_pkg::TAG_DIV] = (mode1_r == fpa_pkg::MODE_DIV);
  end

  fpa_div_pipe #(
    .DW (DW),
    .FB (FB),
    .TW (TW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v1_r),
    .in_num    (ma1_r),
    .in_den    (mb1_r),
    .in_tag    (tag1),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_rem   (dv_rem),
    .out_den   (dv_den),
    .out_tag   (dv_tag)
  );

  // ---------------------------------------------------------------------
  // Stage 2: multiplier partial products, and every simple operation.
  // ---------------------------------------------------------------------
  logic signed [VW-1:0]   ae, be;
  logic signed [VW-1:0]   simple_nxt;
  logic                   cmp_nxt;
  logic [DW+HW-1:0]       pp_lo_r;
  logic [PW-HW-1:0]       pp_hi_r;
  logic signed [VW-1:0]   o2_r;
  logic                   cmp2_r, mul2_r, neg2_r;

  assign ae = VW'(a1_r);
  assign be = VW'(b1_r);

  always_comb begin
    simple_nxt = '0;
    cmp_nxt    = 1'b0;
    case (mode1_r)
      fpa_pkg::MODE_ADD:  simple_nxt = ae + be;
      fpa_pkg::MODE_SUB:  simple_nxt = ae - be;
      fpa_pkg::MODE_INC:  simple_nxt = ae + VW'(1);
      fpa_pkg::MODE_DEC:  simple_nxt = ae - VW'(1);
      fpa_pkg::MODE_MAX:  simple_nxt = (a1_r > b1_r) ? ae : be;
      fpa_pkg::MODE_MIN:  simple_nxt = (a1_r < b1_r) ? ae : be;
      fpa_pkg::MODE_ITOF: simple_nxt = ae <<< FB;
      fpa_pkg::MODE_FTOI: simple_nxt = ae >>> FB;
      fpa_pkg::MODE_GT:   cmp_nxt = (a1_r > b1_r);
      fpa_pkg::MODE_LT:   cmp_nxt = (a1_r < b1_r);
      fpa_pkg::MODE_GE:   cmp_nxt = (a1_r >= b1_r);
      fpa_pkg::MODE_LE:   cmp_nxt = (a1_r <= b1_r);
      fpa_pkg::MODE_EQ:   cmp_nxt = (a1_r == b1_r);
      fpa_pkg::MODE_NE:   cmp_nxt = (a1_r != b1_r);
      default: begin
        simple_nxt = '0;
        cmp_nxt    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    pp_lo_r <= (DW + HW)'(ma1_r) * (DW + HW)'(mb1_r[HW-1:0]);
    pp_hi_r <= (PW - HW)'(ma1_r) * (PW - HW)'(mb1_r[DW-1:HW]);
    o2_r    <= simple_nxt;
    cmp2_r  <= cmp_nxt;
    mul2_r  <= (mode1_r == fpa_pkg::MODE_MUL);
    neg2_r  <= neg1_r;
  end

  // ---------------------------------------------------------------------
  // Stage 3: sum the partial products with the rounding half, then scale.
  // ---------------------------------------------------------------------
  logic [PW-1:0]        psum;
  logic [MW-1:0]        m3_r;
  logic signed [VW-1:0] o3_r;
  logic                 cmp3_r, mul3_r, neg3_r;

  assign psum = PW'(pp_lo_r) + (PW'(pp_hi_r) << HW) + HALF;

  always_ff @(posedge clk) begin
    m3_r   <= psum[PW-1:FB];
    o3_r   <= o2_r;
    cmp3_r <= cmp2_r;
    mul3_r <= mul2_r;
    neg3_r <= neg2_r;
  end

  // ---------------------------------------------------------------------
  // Stage 4: a product far out of range is clipped to a value that still
  // saturates, so the short path only needs VW bits. Then the delay line.
  // ---------------------------------------------------------------------
  logic signed [VW-1:0] mc, mul_val, o4_nxt;
  logic signed [VW-1:0] oth_r [DL];
  logic                 ocmp_r [DL];

  assign mc      = (m3_r > LIM_M) ? CLIP : VW'(m3_r);
  assign mul_val = neg3_r ? -mc : mc;
  assign o4_nxt  = mul3_r ? mul_val : o3_r;

  always_ff @(posedge clk) begin
    oth_r[0]  <= o4_nxt;
    ocmp_r[0] <= cmp3_r;
    for (int k = 1; k < DL; k++) begin
      oth_r[k]  <= oth_r[k-1];
      ocmp_r[k] <= ocmp_r[k-1];
    end
  end

  // ---------------------------------------------------------------------
  // Stage F1: round the quotient to nearest, ties away from zero.
  // ---------------------------------------------------------------------
  logic          f1_v_r;
  logic [NW:0]   q1_r;
  logic [TW-1:0] tag_f1_r;
  logic          rnd;

  assign rnd = ({dv_rem, 1'b0} >= {1'b0, dv_den});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else begin
      f1_v_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    q1_r     <= (NW + 1)'(dv_quo) + (NW + 1)'(rnd);
    tag_f1_r <= dv_tag;
  end

  // ---------------------------------------------------------------------
  // Stage F2: sign the quotient and pick between the two paths.
  // ---------------------------------------------------------------------
  logic signed [VW-1:0] qc, div_val;
  logic                 f2_v_r;
  logic signed [VW-1:0] val2_r;
  logic                 cmp_f2_r, dz2_r;

  assign qc      = (q1_r > LIM_Q) ? CLIP : VW'(q1_r);
  assign div_val = tag_f1_r[fpa_pkg::TAG_BZ]  ? '0 :
                   tag_f1_r[fpa_pkg::TAG_NEG] ? -qc : qc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    val2_r   <= tag_f1_r[fpa_pkg::TAG_DIV] ? div_val : oth_r[DL-1];
    cmp_f2_r <= tag_f1_r[fpa_pkg::TAG_DIV] ? 1'b0 : ocmp_r[DL-1];
    dz2_r    <= tag_f1_r[fpa_pkg::TAG_DIV] & tag_f1_r[fpa_pkg::TAG_BZ];
  end

  // ---------------------------------------------------------------------
  // Stage F3: saturate to the data width and register the result.
  // Comparisons and division by zero carry zero, which never saturates.
  // ---------------------------------------------------------------------
  logic                  sat_hi, sat_lo;
  fpa_pkg::out_item_t    out_nxt;
  logic                  out_valid_r;
  fpa_pkg::out_item_t    out_item_r;

  assign sat_hi = (val2_r > SAT_MAX);
  assign sat_lo = (val2_r < SAT_MIN);

  always_comb begin
    out_nxt.compare_true = cmp_f2_r;
    if (sat_hi) begin
      out_nxt.result = SAT_MAX[DW-1:0];
    end else if (sat_lo) begin
      out_nxt.result = SAT_MIN[DW-1:0];
    end else begin
      out_nxt.result = val2_r[DW-1:0];
    end
    if (dz2_r) begin
      out_nxt.status = fpa_pkg::ST_DIV_ZERO;
    end else if (sat_hi || sat_lo) begin
      out_nxt.status = fpa_pkg::ST_SAT;
    end else begin
      out_nxt.status = fpa_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------
  // Checks on the result stage.
  // ---------------------------------------------------------------------
  // A division by zero reports zero and no comparison outcome.
  a_dz_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == fpa_pkg::ST_DIV_ZERO) |->
      (out_item.result == '0 && !out_item.compare_true))
    else $error("division by zero result is not zero");

  // A true comparison carries a zero result and an ok status.
  a_cmp_clean : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.compare_true) |->
      (out_item.result == '0 && out_item.status == fpa_pkg::ST_OK))
    else $error("comparison result carries data or status");

  // A saturated result sits at one of the two range limits.
  a_sat_limit : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == fpa_pkg::ST_SAT) |->
      (out_item.result == SAT_MAX[DW-1:0] || out_item.result == SAT_MIN[DW-1:0]))
    else $error("saturated result is not at a range limit");

  // The divider and the result stage stay in step: an item that leaves the divider
  // passes the rounding, sign and select, and saturation registers to the output.
  a_lat_align : assert property (@(posedge clk) disable iff (!rst_n)
    $past(dv_valid, 3) && $past(rst_n, 3) |-> out_valid)
    else $error("result lost between divider and output");

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

  // Pipeline depth of the block at the default parameters.
  localparam int PIPE_DEPTH = fpa_pkg::DATA_WIDTH + fpa_pkg::FRAC_BITS + 3;
  localparam int N_RANDOM   = 1750;
  localparam int FB         = fpa_pkg::FRAC_BITS;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  fpa_pkg::in_item_t  in_item = '0;
  logic               out_valid;
  fpa_pkg::out_item_t out_item;

  always #6 clk = ~clk;

  fixed_point_alu dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Results still owed by the block, oldest first.
  fpa_pkg::out_item_t pending_results[$];
  int        mismatch_count = 0;
  int        unexpected_count = 0;
  int        results_seen = 0;
  int        items_sent = 0;

  // Clamp a wide signed value to the 32-bit range; flag when it clamps.
  function automatic logic signed [31:0] saturate(input logic signed [63:0] v,
                                                  inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  // Computes the result the ALU must give for one item.
  function automatic fpa_pkg::out_item_t alu_result(input fpa_pkg::in_item_t it);
    logic signed [63:0] a, b, r;
    logic [63:0]        ma, mb, prod, num, quo, rem;
    logic               neg, sat, is_cmp, cmp;
    fpa_pkg::out_item_t o;
    a = it.operand_a;
    b = it.operand_b;
    r = '0;
    sat = 1'b0;
    is_cmp = 1'b0;
    cmp = 1'b0;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    neg = (a < 0) != (b < 0);
    o = '0;
    case (it.mode)
      fpa_pkg::MODE_ADD: r = a + b;
      fpa_pkg::MODE_SUB: r = a - b;
      fpa_pkg::MODE_MUL: begin
        // Product magnitude fits in 63 bits, so rounding cannot wrap.
        prod = ma * mb;
        prod = (prod + (64'd1 << (FB - 1))) >> FB;
        r = neg ? -$signed(prod) : $signed(prod);
      end
      fpa_pkg::MODE_DIV: begin
        if (b == 0) begin
          o.status = fpa_pkg::ST_DIV_ZERO;
          return o;
        end
        num = ma << FB;
        quo = num / mb;
        rem = num % mb;
        if (rem * 2 >= mb) quo = quo + 1;
        r = neg ? -$signed(quo) : $signed(quo);
      end
      fpa_pkg::MODE_GT: begin is_cmp = 1'b1; cmp = a > b; end
      fpa_pkg::MODE_LT: begin is_cmp = 1'b1; cmp = a < b; end
      fpa_pkg::MODE_GE: begin is_cmp = 1'b1; cmp = a >= b; end
      fpa_pkg::MODE_LE: begin is_cmp = 1'b1; cmp = a <= b; end
      fpa_pkg::MODE_EQ: begin is_cmp = 1'b1; cmp = a == b; end
      fpa_pkg::MODE_NE: begin is_cmp = 1'b1; cmp = a != b; end
      fpa_pkg::MODE_INC: r = a + 1;
      fpa_pkg::MODE_DEC: r = a - 1;
      fpa_pkg::MODE_MAX: r = (a > b) ? a : b;
      fpa_pkg::MODE_MIN: r = (a < b) ? a : b;
      fpa_pkg::MODE_ITOF: r = a * (64'sd1 <<< FB);
      default: r = a >>> FB;  // Floor toward minus infinity.
    endcase
    if (is_cmp) begin
      o.compare_true = cmp;
    end else begin
      o.result = saturate(r, sat);
      o.status = sat ? fpa_pkg::ST_SAT : fpa_pkg::ST_OK;
    end
    return o;
  endfunction

  // Directed table. When check_literal is set the typed-in result is used
  // instead of the predictor, for the rows that can be read off directly.
  typedef struct {
    fpa_pkg::in_item_t  stim;
    logic               check_literal;
    fpa_pkg::out_item_t literal;
  } directed_row_t;

  directed_row_t directed_rows[$];

  function automatic directed_row_t row(input fpa_pkg::mode_t m, input logic [31:0] a,
                                        input logic [31:0] b, input logic lit,
                                        input logic [31:0] res, input logic cmp,
                                        input fpa_pkg::status_t st);
    directed_row_t d;
    d.stim.mode = m;
    d.stim.operand_a = a;
    d.stim.operand_b = b;
    d.check_literal = lit;
    d.literal.result = res;
    d.literal.compare_true = cmp;
    d.literal.status = st;
    return d;
  endfunction

  initial begin
    // Saturation at both ends of the range.
    directed_rows.push_back(row(fpa_pkg::MODE_ADD, 32'h7FFF_FFFF, 32'h1, 1, 32'h7FFF_FFFF, 0,
                                fpa_pkg::ST_SAT));
    directed_rows.push_back(row(fpa_pkg::MODE_SUB, 32'h8000_0000, 32'h1, 1, 32'h8000_0000, 0,
                                fpa_pkg::ST_SAT));
    directed_rows.push_back(row(fpa_pkg::MODE_INC, 32'h7FFF_FFFF, 32'h0, 1, 32'h7FFF_FFFF, 0,
                                fpa_pkg::ST_SAT));
    directed_rows.push_back(row(fpa_pkg::MODE_DEC, 32'h8000_0000, 32'h0, 1, 32'h8000_0000, 0,
                                fpa_pkg::ST_SAT));
    // Division by zero returns zero with its own status.
    directed_rows.push_back(row(fpa_pkg::MODE_DIV, 32'h0000_0100, 32'h0, 1, 32'h0, 0,
                                fpa_pkg::ST_DIV_ZERO));
    directed_rows.push_back(row(fpa_pkg::MODE_DIV, 32'h8000_0000, 32'h0, 1, 32'h0, 0,
                                fpa_pkg::ST_DIV_ZERO));
    // 1.0 * 1.0 and 1.0 / 1.0 in Q24.8.
    directed_rows.push_back(row(fpa_pkg::MODE_MUL, 32'h100, 32'h100, 1, 32'h100, 0,
                                fpa_pkg::ST_OK));
    directed_rows.push_back(row(fpa_pkg::MODE_DIV, 32'h100, 32'h100, 1, 32'h100, 0,
                                fpa_pkg::ST_OK));
    // Rounding ties away from zero on both signs, then products and quotients that saturate.
    directed_rows.push_back(row(fpa_pkg::MODE_MUL, 32'h1, 32'h80, 0, 0, 0, fpa_pkg::ST_OK));
    directed_rows.push_back(row(fpa_pkg::MODE_MUL, 32'hFFFF_FFFF, 32'h80, 0, 0, 0,
                                fpa_pkg::ST_OK));
    directed_rows.push_back(row(fpa_pkg::MODE_DIV, 32'h1, 32'h200, 0, 0, 0, fpa_pkg::ST_OK));
    directed_rows.push_back(row(fpa_pkg::MODE_DIV, 32'hFFFF_FFFF, 32'h200, 0, 0, 0,
                                fpa_pkg::ST_OK));
    directed_rows.push_back(row(fpa_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000, 1,
                                32'h7FFF_FFFF, 0, fpa_pkg::ST_SAT));
    directed_rows.push_back(row(fpa_pkg::MODE_DIV, 32'h8000_0000, 32'h1, 1, 32'h8000_0000, 0,
                                fpa_pkg::ST_SAT));
    // Comparisons at the extremes and on equal operands; the result field stays zero.
    directed_rows.push_back(row(fpa_pkg::MODE_GT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h0, 1,
                                fpa_pkg::ST_OK));
    directed_rows.push_back(row(fpa_pkg::MODE_LT, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h0, 0,
                                fpa_pkg::ST_OK));
    directed_rows.push_back(row(fpa_pkg::MODE_GE, 32'h5, 32'h5, 1, 32'h0, 1, fpa_pkg::ST_OK));
    directed_rows.push_back(row(fpa_pkg::MODE_LE, 32'h8000_0000, 32'h8000_0000, 1, 32'h0, 1,
                                fpa_pkg::ST_OK));
    directed_rows.push_back(row(fpa_pkg::MODE_EQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 32'h0, 1,
                                fpa_pkg::ST_OK));
    directed_rows.push_back(row(fpa_pkg::MODE_NE, 32'h0, 32'h0, 1, 32'h0, 0, fpa_pkg::ST_OK));
    directed_rows.push_back(row(fpa_pkg::MODE_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                                32'h7FFF_FFFF, 0, fpa_pkg::ST_OK));
    directed_rows.push_back(row(fpa_pkg::MODE_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                                32'h8000_0000, 0, fpa_pkg::ST_OK));
    directed_rows.push_back(row(fpa_pkg::MODE_ITOF, 32'h0080_0000, 32'h0, 1, 32'h7FFF_FFFF, 0,
                                fpa_pkg::ST_SAT));
    directed_rows.push_back(row(fpa_pkg::MODE_ITOF, 32'hFF80_0000, 32'h0, 1, 32'h8000_0000, 0,
                                fpa_pkg::ST_OK));
    // Conversion back floors negative values.
    directed_rows.push_back(row(fpa_pkg::MODE_FTOI, 32'hFFFF_FFFF, 32'h0, 1, 32'hFFFF_FFFF, 0,
                                fpa_pkg::ST_OK));
  end

  // Draw an operand: half full range, the rest near the extremes or small values
  // so that saturation, rounding and equal operands are all hit often.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      1: return $signed($urandom_range(0, 2047)) - 1024;
      2: return $urandom & 32'h0000_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offer one item: idle for a random gap, then hold start until accepted.
  task automatic send_item(input fpa_pkg::in_item_t it, input fpa_pkg::out_item_t want);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(want);
    items_sent++;
  endtask

  // Results are taken in the cycle they appear; compare with the oldest owed.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        unexpected_count++;
        if (unexpected_count + mismatch_count <= 10)
          $display("unexpected result %h at %0t", out_item, $realtime);
      end else begin
        fpa_pkg::out_item_t want;
        want = pending_results.pop_front();
        if (out_item.result !== want.result || out_item.compare_true !== want.compare_true ||
            out_item.status !== want.status) begin
          mismatch_count++;
          if (mismatch_count + unexpected_count <= 10)
            $display("mismatch: expected result %h cmp %b status %0d, got %h cmp %b status %0d",
                     want.result, want.compare_true, want.status, out_item.result,
                     out_item.compare_true, out_item.status);
        end
      end
    end
  end

  initial begin
    fpa_pkg::in_item_t it;
    int                settle;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows first.
    foreach (directed_rows[i])
      send_item(directed_rows[i].stim,
                directed_rows[i].check_literal ? directed_rows[i].literal
                                               : alu_result(directed_rows[i].stim));

    // Random part: every mode, operands biased toward interesting values,
    // with occasional runs of back-to-back items.
    for (int n = 0; n < N_RANDOM; n++) begin
      it.mode = fpa_pkg::mode_t'($urandom_range(0, 15));
      it.operand_a = pick_operand();
      it.operand_b = $urandom_range(0, 15) == 0 ? it.operand_a : pick_operand();
      if (it.mode == fpa_pkg::MODE_DIV && $urandom_range(0, 19) == 0) it.operand_b = '0;
      send_item(it, alu_result(it));
    end
    start <= 1'b0;

    // Drain, then keep the clock running for stray results.
    settle = 0;
    while (pending_results.size() != 0 && settle < 100 * PIPE_DEPTH) begin
      @(posedge clk);
      settle++;
    end
    repeat (2 * PIPE_DEPTH) @(posedge clk);

    $display("Sent %0d items over all sixteen modes, checked %0d results.", items_sent,
             results_seen);
    if (mismatch_count == 0 && unexpected_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing", mismatch_count,
               unexpected_count, pending_results.size());
      $display("TB_ERROR");
    end
    $finish;
  end

  // Worst case is about 1800 items, each after its longest idle gap, plus the pipeline;
  // this bound is many times that.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/fpa_pkg.sv
rtl/fpa_div_pipe.sv
rtl/fixed_point_alu.sv
verif/tb_top.sv
